// File: sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CHK_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("invariant check failed");

`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define CHK_ALWAYS(lbl, clk, rstn, expr)
`define CHK_IMPLY(lbl, clk, rstn, ante, cons)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: sv/mmes_pkg.sv
`default_nettype none

package mmes_pkg;

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 12;
    localparam int CFG_DW   = 12;
    localparam int STR_W    = 7;
    // Compare domain for widths: holds any frame_width value and MAX_WIDTH up to 8192
    localparam int CMP_W    = 14;
    localparam int PROD_W   = PIX_W + STR_W;
    localparam int MIN_DIM  = 3;

    localparam logic [STR_W-1:0]  BLEND_FULL  = 7'd127;
    localparam int                BLEND_SHIFT = 7;

    localparam logic [CFG_DW-1:0] RST_WIDTH     = 12'd720;
    localparam logic [CFG_DW-1:0] RST_HEIGHT    = 12'd576;
    localparam logic [STR_W-1:0]  RST_STRENGTH  = 7'd64;
    localparam logic [PIX_W-1:0]  RST_THRESHOLD = 8'd128;

    typedef enum logic [1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_STRENGTH  = 2'd2,
        CFG_THRESHOLD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             end_of_line;
        logic             end_of_frame;
    } t_out;

    // One window column, top row first
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
    } t_span;

    typedef struct packed {
        logic interior;
        logic eol;
        logic eof;
    } t_tag;

endpackage

`default_nettype wire

// File: sv/minmax_edge_sharpen_3x3.sv
`default_nettype none
// Channel   Direction  Handshake                    Payload
// in        sink       i_in_valid / o_in_ready      i_in_data   (t_in: pixel, flush)
// out       source     o_out_valid / i_out_ready    o_out_data  (t_out: pixel_out, eol, eof)
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item per clock unless stalled; a line store reads and writes at most once per cycle.
// A result passes stage 1 with the store reads, the cells, r3, r4 and the output register.
// An output stall freezes every stage at once; input ready follows the output register.
// Reset clears counters, valid bits and the window; line stores are not cleared.
// Configuration is always ready; a width or height write restarts the frame position.

`include "assert_macros.svh"

module minmax_edge_sharpen_3x3 #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire mmes_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output mmes_pkg::t_out                       o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire mmes_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [mmes_pkg::CFG_DW-1:0]     i_cfg_data
);

    import mmes_pkg::*;

    localparam int                CW   = $clog2(MAX_WIDTH);
    localparam logic [CMP_W-1:0]  MAXW = CMP_W'(MAX_WIDTH);

    logic [CFG_DW-1:0] r_frame_width;
    logic [CFG_DW-1:0] r_frame_height;
    logic [STR_W-1:0]  r_strength;
    logic [PIX_W-1:0]  r_threshold;

    logic [CW-1:0]     r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [CW-1:0]     r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [CW-1:0]     n_in_col;
    logic [ROW_W-1:0]  n_in_row;
    logic [CW-1:0]     n_out_col;
    logic [ROW_W-1:0]  n_out_row;

    logic [CMP_W-1:0]  w_fw;
    logic [CMP_W-1:0]  w_w;
    logic [ROW_W-1:0]  w_h;
    logic [CMP_W-1:0]  w_col_cur;
    logic [CMP_W-1:0]  w_col_nx;
    logic [CMP_W-1:0]  w_ocol_nx;
    logic [CMP_W-1:0]  w_ocol_2;
    logic [ROW_W:0]    w_orow_nx;
    logic [ROW_W:0]    w_orow_2;
    logic              w_col_last;
    logic              w_tail;
    logic              w_adv;
    logic              w_take;
    logic              w_emit;
    logic              w_eol;
    logic              w_eof;
    logic              w_interior;
    logic              w_cfg_geom;

    logic              r_s1_valid;
    logic              r_s1_tail;
    logic              r_s1_emit;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [CW-1:0]     r_s1_col;
    t_tag              r_s1_tag;
    logic              r_s2_valid;
    t_tag              r_s2_tag;

    logic [PIX_W-1:0]  w_up_rd;
    logic [PIX_W-1:0]  w_mid_rd;
    logic              w_up_we;
    logic              w_load;
    t_col              w_col_new;
    t_col              w_col_2;
    t_col              w_col_1;
    t_col              w_col_0;
    t_span             w_span_2;
    t_span             w_span_1;
    t_span             w_span_0;

    // Effective geometry
    assign w_fw = CMP_W'(r_frame_width);
    assign w_w  = (w_fw < CMP_W'(MIN_DIM)) ? CMP_W'(MIN_DIM) : ((w_fw > MAXW) ? MAXW : w_fw);
    assign w_h  = (r_frame_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : r_frame_height;

    assign w_col_cur  = CMP_W'(r_in_col);
    assign w_col_nx   = w_col_cur + CMP_W'(1);
    assign w_col_last = w_col_nx >= w_w;
    assign w_tail     = r_in_row >= w_h;

    assign o_in_ready = w_adv;
    assign o_cfg_ready = 1'b1;
    // Drop a flush while rows still arrive, and a pixel during the tail
    assign w_take = i_in_valid && w_adv && (i_in_data.flush == w_tail);

    assign w_emit = w_tail || (r_in_row >= ROW_W'(2)) ||
                    ((r_in_row == ROW_W'(1)) && (r_in_col != '0));

    assign w_ocol_nx  = CMP_W'(r_out_col) + CMP_W'(1);
    assign w_ocol_2   = CMP_W'(r_out_col) + CMP_W'(2);
    assign w_orow_nx  = (ROW_W+1)'(r_out_row) + (ROW_W+1)'(1);
    assign w_orow_2   = (ROW_W+1)'(r_out_row) + (ROW_W+1)'(2);
    assign w_eol      = w_ocol_nx >= w_w;
    assign w_eof      = w_eol && (w_orow_nx >= {1'b0, w_h});
    assign w_interior = (r_out_row != '0) && (w_orow_2 <= {1'b0, w_h}) &&
                        (r_out_col != '0) && (w_ocol_2 <= w_w);

    assign w_cfg_geom = i_cfg_valid &&
                        ((i_cfg_index == CFG_WIDTH) || (i_cfg_index == CFG_HEIGHT));

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_take) begin
            if (w_col_last) begin
                n_in_col = '0;
                if (!w_tail) begin
                    n_in_row = r_in_row + ROW_W'(1);
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (w_emit) begin
                if (w_eol) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
            // Frame done: restart every position
            if (w_emit && w_eof) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end
        if (w_cfg_geom) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
            r_strength     <= RST_STRENGTH;
            r_threshold    <= RST_THRESHOLD;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:     r_frame_width  <= i_cfg_data;
                    CFG_HEIGHT:    r_frame_height <= i_cfg_data;
                    CFG_STRENGTH:  r_strength     <= i_cfg_data[STR_W-1:0];
                    CFG_THRESHOLD: r_threshold    <= i_cfg_data[PIX_W-1:0];
                    default:       r_threshold    <= r_threshold;
                endcase
            end
            if (w_adv) begin
                r_s1_valid <= w_take;
                r_s2_valid <= r_s1_valid && r_s1_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_take) begin
                r_s1_tail         <= w_tail;
                r_s1_emit         <= w_emit;
                r_s1_pix          <= w_tail ? '0 : i_in_data.pixel;
                r_s1_col          <= r_in_col;
                r_s1_tag.interior <= w_interior;
                r_s1_tag.eol      <= w_eol;
                r_s1_tag.eof      <= w_eof;
            end
            r_s2_tag <= r_s1_tag;
        end
    end

    // Middle store takes the new pixel at transfer; upper store takes the
    // old middle word at the next advance, when its read data is out
    assign w_up_we = w_adv && r_s1_valid && !r_s1_tail;

    mmes_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_store_mid (
        .i_clk   (i_clk),
        .i_we    (w_take && !w_tail),
        .i_waddr (r_in_col),
        .i_wdata (i_in_data.pixel),
        .i_re    (w_take),
        .i_raddr (r_in_col),
        .o_rdata (w_mid_rd)
    );

    mmes_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_store_up (
        .i_clk   (i_clk),
        .i_we    (w_up_we),
        .i_waddr (r_s1_col),
        .i_wdata (w_mid_rd),
        .i_re    (w_take),
        .i_raddr (r_in_col),
        .o_rdata (w_up_rd)
    );

    assign w_load        = w_adv && r_s1_valid;
    assign w_col_new.top = w_up_rd;
    assign w_col_new.mid = w_mid_rd;
    assign w_col_new.bot = r_s1_pix;

    mmes_cell u_cell_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_col   (w_col_new),
        .o_col   (w_col_2),
        .o_span  (w_span_2)
    );

    mmes_cell u_cell_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_col   (w_col_2),
        .o_col   (w_col_1),
        .o_span  (w_span_1)
    );

    mmes_cell u_cell_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_col   (w_col_1),
        .o_col   (w_col_0),
        .o_span  (w_span_0)
    );

    mmes_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ready     (i_out_ready),
        .o_adv       (w_adv),
        .i_valid     (r_s2_valid),
        .i_tag       (r_s2_tag),
        .i_span_l    (w_span_0),
        .i_span_c    (w_span_1),
        .i_span_r    (w_span_2),
        .i_centre    (w_col_1.mid),
        .i_strength  (r_strength),
        .i_threshold (r_threshold),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data)
    );

    // The left column only feeds the extremes; its pixels leave the chain here
    logic w_left_unused;
    assign w_left_unused = ^w_col_0;

    `CHK_ALWAYS(a_col_range, i_clk, i_rst_n, w_col_cur < w_w)
    `CHK_ALWAYS(a_row_range, i_clk, i_rst_n, r_in_row <= w_h)
    `CHK_IMPLY(a_eof_eol, i_clk, i_rst_n, o_out_valid && o_out_data.end_of_frame, o_out_data.end_of_line)
    `CHK_IMPLY(a_store_ports, i_clk, i_rst_n, w_up_we && w_take, r_s1_col != r_in_col)
    `CHK_NEXT(a_eof_restart, i_clk, i_rst_n, w_take && w_emit && w_eof, (r_in_row == '0) && (r_in_col == '0) && (r_out_row == '0) && (r_out_col == '0))

endmodule

`default_nettype wire

// File: sv/mmes_ram.sv
`default_nettype none

module mmes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and a write to one address return the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/mmes_cell.sv
`default_nettype none

module mmes_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire mmes_pkg::t_col i_col,
    output mmes_pkg::t_col      o_col,
    output mmes_pkg::t_span     o_span
);

    import mmes_pkg::*;

    t_col             r_col;
    t_span            r_span;
    t_span            n_span;
    logic [PIX_W-1:0] w_lo01;
    logic [PIX_W-1:0] w_hi01;

    // Column extremes travel with the column as it moves along the chain
    always_comb begin
        w_lo01    = (i_col.top < i_col.mid) ? i_col.top : i_col.mid;
        w_hi01    = (i_col.top > i_col.mid) ? i_col.top : i_col.mid;
        n_span.lo = (w_lo01 < i_col.bot) ? w_lo01 : i_col.bot;
        n_span.hi = (w_hi01 > i_col.bot) ? w_hi01 : i_col.bot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_span <= '0;
        end else if (i_load) begin
            r_col  <= i_col;
            r_span <= n_span;
        end
    end

    assign o_col  = r_col;
    assign o_span = r_span;

endmodule

`default_nettype wire

// File: sv/mmes_blend.sv
`default_nettype none

module mmes_blend (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_ready,
    output logic                                o_adv,
    input  wire logic                           i_valid,
    input  wire mmes_pkg::t_tag                 i_tag,
    input  wire mmes_pkg::t_span                i_span_l,
    input  wire mmes_pkg::t_span                i_span_c,
    input  wire mmes_pkg::t_span                i_span_r,
    input  wire logic [mmes_pkg::PIX_W-1:0]     i_centre,
    input  wire logic [mmes_pkg::STR_W-1:0]     i_strength,
    input  wire logic [mmes_pkg::PIX_W-1:0]     i_threshold,
    output logic                                o_valid,
    output mmes_pkg::t_out                      o_data
);

    import mmes_pkg::*;

    logic [PIX_W-1:0]  w_mn_a;
    logic [PIX_W-1:0]  w_mx_a;
    logic [PIX_W-1:0]  w_mn;
    logic [PIX_W-1:0]  w_mx;
    logic [PIX_W-1:0]  w_dlo;
    logic [PIX_W-1:0]  w_dhi;
    logic              w_pick_hi;
    logic [PIX_W-1:0]  w_dist;
    logic [PIX_W-1:0]  w_ext;
    logic              w_sharp;
    logic [STR_W-1:0]  w_wc;
    logic [PROD_W-1:0] w_sum;
    logic              w_adv;

    logic              r3_valid;
    t_tag              r3_tag;
    logic              r3_sharp;
    logic [PIX_W-1:0]  r3_ext;
    logic [PIX_W-1:0]  r3_c;

    logic              r4_valid;
    t_tag              r4_tag;
    logic              r4_sharp;
    logic [PROD_W-1:0] r4_pe;
    logic [PROD_W-1:0] r4_pc;
    logic [PIX_W-1:0]  r4_c;

    logic              r_out_valid;
    t_out              r_out;

    assign w_adv = !r_out_valid || i_ready;

    // Window extremes and choice of the nearer one (minimum wins a tie)
    always_comb begin
        w_mn_a    = (i_span_l.lo < i_span_c.lo) ? i_span_l.lo : i_span_c.lo;
        w_mx_a    = (i_span_l.hi > i_span_c.hi) ? i_span_l.hi : i_span_c.hi;
        w_mn      = (w_mn_a < i_span_r.lo) ? w_mn_a : i_span_r.lo;
        w_mx      = (w_mx_a > i_span_r.hi) ? w_mx_a : i_span_r.hi;
        w_dlo     = i_centre - w_mn;
        w_dhi     = w_mx - i_centre;
        w_pick_hi = w_dlo > w_dhi;
        w_dist    = w_pick_hi ? w_dhi : w_dlo;
        w_ext     = w_pick_hi ? w_mx : w_mn;
        w_sharp   = i_tag.interior && (w_dist < i_threshold);
    end

    assign w_wc  = BLEND_FULL - i_strength;
    assign w_sum = r4_pe + r4_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid    <= i_valid;
            r4_valid    <= r3_valid;
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_tag   <= i_tag;
            r3_sharp <= w_sharp;
            r3_ext   <= w_ext;
            r3_c     <= i_centre;

            r4_tag   <= r3_tag;
            r4_sharp <= r3_sharp;
            r4_pe    <= {{STR_W{1'b0}}, r3_ext} * {{PIX_W{1'b0}}, i_strength};
            r4_pc    <= {{STR_W{1'b0}}, r3_c} * {{PIX_W{1'b0}}, w_wc};
            r4_c     <= r3_c;

            r_out.pixel_out    <= r4_sharp ? w_sum[BLEND_SHIFT +: PIX_W] : r4_c;
            r_out.end_of_line  <= r4_tag.eol;
            r_out.end_of_frame <= r4_tag.eof;
        end
    end

    assign o_adv   = w_adv;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
    import mmes_pkg::*;

    localparam int LINE_MAX   = 2048;
    localparam int RAND_ITEMS = 1900;
    // five stages to the output register, plus margin
    localparam int SETTLE_CYC = 12;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_FLUSH} row_kind_t;
    typedef enum int {STY_NOISE, STY_RAMP, STY_EDGE} pix_style_t;

    typedef struct packed {
        row_kind_t        kind;
        t_cfg_idx         idx;
        logic [CFG_DW-1:0] val;
        logic             typed;
        t_out             want;
    } dir_row_t;

    localparam int DIR_N = 21;
    localparam dir_row_t DIRECTED [DIR_N] = '{
        // reset geometry: these only fill the first line, no output
        '{ROW_PIX,   CFG_WIDTH,     12'd12,  1'b0, '0},
        '{ROW_PIX,   CFG_WIDTH,     12'd255, 1'b0, '0},
        // geometry writes restart the frame; height 0 clamps to 3
        '{ROW_CFG,   CFG_WIDTH,     12'd3,   1'b0, '0},
        '{ROW_CFG,   CFG_HEIGHT,    12'd0,   1'b0, '0},
        '{ROW_CFG,   CFG_STRENGTH,  12'd127, 1'b0, '0},
        '{ROW_CFG,   CFG_THRESHOLD, 12'd255, 1'b0, '0},
        '{ROW_PIX,   CFG_WIDTH,     12'd0,   1'b0, '0},
        '{ROW_PIX,   CFG_WIDTH,     12'd255, 1'b0, '0},
        // flush while lines still arrive: dropped
        '{ROW_FLUSH, CFG_WIDTH,     12'hA5,  1'b0, '0},
        '{ROW_PIX,   CFG_WIDTH,     12'd17,  1'b0, '0},
        '{ROW_PIX,   CFG_WIDTH,     12'd200, 1'b0, '0},
        '{ROW_PIX,   CFG_WIDTH,     12'd90,  1'b1, '{8'd0,   1'b0, 1'b0}},
        '{ROW_PIX,   CFG_WIDTH,     12'd255, 1'b1, '{8'd255, 1'b0, 1'b0}},
        '{ROW_PIX,   CFG_WIDTH,     12'd0,   1'b1, '{8'd17,  1'b1, 1'b0}},
        '{ROW_PIX,   CFG_WIDTH,     12'd45,  1'b1, '{8'd200, 1'b0, 1'b0}},
        // the center pixel is the only interior one
        '{ROW_PIX,   CFG_WIDTH,     12'd128, 1'b0, '0},
        '{ROW_FLUSH, CFG_WIDTH,     12'h5A,  1'b1, '{8'd255, 1'b1, 1'b0}},
        // pixel during the tail: dropped
        '{ROW_PIX,   CFG_WIDTH,     12'd77,  1'b0, '0},
        '{ROW_FLUSH, CFG_WIDTH,     12'hFF,  1'b1, '{8'd0,   1'b0, 1'b0}},
        '{ROW_FLUSH, CFG_WIDTH,     12'd0,   1'b1, '{8'd45,  1'b0, 1'b0}},
        '{ROW_FLUSH, CFG_WIDTH,     12'd1,   1'b1, '{8'd128, 1'b1, 1'b1}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in               i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out              o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    t_cfg_idx          i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    // predictor state
    logic [CFG_DW-1:0] cfg_w;
    logic [CFG_DW-1:0] cfg_h;
    logic [STR_W-1:0]  cfg_gain;
    logic [PIX_W-1:0]  cfg_thr;
    bit [PIX_W-1:0]    upper_line [LINE_MAX];
    bit [PIX_W-1:0]    middle_line [LINE_MAX];
    bit [PIX_W-1:0]    win [9];
    int                rx_col, rx_row, tx_col, tx_row;

    t_out pending_pix [$];
    t_out head_pix;

    int errors;
    int items_sent;
    int real_items;
    int frames_done;
    int results_seen;
    int phases;
    bit no_stall;

    minmax_edge_sharpen_3x3 #(.MAX_WIDTH(LINE_MAX)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #24000000;
        $display("Timeout at %0t with %0d output pixels outstanding", $time, pending_pix.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int eff_w();
        if (cfg_w < MIN_DIM) return MIN_DIM;
        if (cfg_w > LINE_MAX) return LINE_MAX;
        return int'(cfg_w);
    endfunction

    function automatic int eff_h();
        if (cfg_h < MIN_DIM) return MIN_DIM;
        return int'(cfg_h);
    endfunction

    function automatic void rewind_frame();
        rx_col = 0;
        rx_row = 0;
        tx_col = 0;
        tx_row = 0;
    endfunction

    // Advance the window and line stores by one item; return 1 with the pixel it releases.
    function automatic bit sharpen_step(input t_in it, output t_out res);
        int  w, h, col, pre, ctr, v, mn, mx, dlo, dhi, r;
        bit  tail, emit, eol, eof;
        res = '0;
        w = eff_w();
        h = eff_h();
        tail = (rx_row >= h);
        col = (rx_col < w) ? rx_col : 0;
        if (it.flush != tail) return 0;

        emit = tail || rx_row >= 2 || (rx_row == 1 && col >= 1);
        pre = win[5];
        for (r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = upper_line[col];
        win[5] = middle_line[col];
        win[8] = tail ? '0 : it.pixel;
        if (!tail) begin
            upper_line[col]  = middle_line[col];
            middle_line[col] = it.pixel;
        end
        if (col + 1 >= w) begin
            rx_col = 0;
            if (rx_row < h) rx_row++;
        end else begin
            rx_col = col + 1;
        end
        if (!emit) return 0;

        // last column of a line takes its centre from the right-middle value saved before the shift
        ctr = (tx_col + 1 >= w) ? int'(pre) : int'(win[4]);
        v = ctr;
        if (tx_row >= 1 && tx_row + 2 <= h && tx_col >= 1 && tx_col + 2 <= w) begin
            mn = 255;
            mx = 0;
            for (r = 0; r < 9; r++) begin
                if (win[r] < mn) mn = win[r];
                if (win[r] > mx) mx = win[r];
            end
            dlo = ctr - mn;
            dhi = mx - ctr;
            if (dlo > dhi) begin
                if (dhi < cfg_thr)
                    v = (mx * int'(cfg_gain) + ctr * (int'(BLEND_FULL) - int'(cfg_gain)))
                        >> BLEND_SHIFT;
            end else if (dlo < cfg_thr) begin
                v = (mn * int'(cfg_gain) + ctr * (int'(BLEND_FULL) - int'(cfg_gain)))
                    >> BLEND_SHIFT;
            end
        end

        eol = (tx_col + 1 >= w);
        eof = eol && (tx_row + 1 >= h);
        if (eof) begin
            rewind_frame();
        end else if (eol) begin
            tx_col = 0;
            tx_row++;
        end else begin
            tx_col++;
        end
        res.pixel_out    = v[PIX_W-1:0];
        res.end_of_line  = eol;
        res.end_of_frame = eof;
        return 1;
    endfunction

    initial begin : out_ready_drv
        int stall;
        forever begin
            stall = no_stall ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pix.size() == 0) begin
                $display("%0t: unexpected output: expected nothing, got %0d/%0b/%0b",
                         $time, o_out_data.pixel_out, o_out_data.end_of_line,
                         o_out_data.end_of_frame);
                errors++;
            end else begin
                head_pix = pending_pix.pop_front();
                results_seen++;
                if (o_out_data.pixel_out !== head_pix.pixel_out ||
                    o_out_data.end_of_line !== head_pix.end_of_line ||
                    o_out_data.end_of_frame !== head_pix.end_of_frame) begin
                    $display("%0t: mismatch (pixel/eol/eof): expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             $time, head_pix.pixel_out, head_pix.end_of_line,
                             head_pix.end_of_frame, o_out_data.pixel_out,
                             o_out_data.end_of_line, o_out_data.end_of_frame);
                    errors++;
                end
            end
        end
    end

    // Keep valid high after the transfer; the next call decides whether it drops.
    task automatic send_item(input t_in it, input bit typed, input t_out want);
        int   gap;
        t_out res;
        bit   got;
        gap = no_stall ? 0 : $urandom_range(0, 6);
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        got = sharpen_step(it, res);
        if (typed)
            pending_pix.push_back(want);
        else if (got)
            pending_pix.push_back(res);
        items_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_WIDTH: begin
                cfg_w = data;
                rewind_frame();
            end
            CFG_HEIGHT: begin
                cfg_h = data;
                rewind_frame();
            end
            CFG_STRENGTH:  cfg_gain = data[STR_W-1:0];
            CFG_THRESHOLD: cfg_thr = data[PIX_W-1:0];
            default: ;
        endcase
    endtask

    // Wait for every pending pixel, then let dropped items clear the pipeline.
    task automatic drain();
        int settle;
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        settle = 0;
        while (settle < SETTLE_CYC) begin
            @(posedge i_clk);
            if (i_out_ready) settle++;
        end
    endtask

    task automatic program_frame(input bit geom, input logic [CFG_DW-1:0] wd,
                                 input logic [CFG_DW-1:0] hd);
        int               pick;
        logic [STR_W-1:0] gain;
        logic [PIX_W-1:0] thr;
        drain();
        phases++;
        if (geom) begin
            write_reg(CFG_WIDTH, wd);
            write_reg(CFG_HEIGHT, hd);
        end
        pick = $urandom_range(0, 7);
        gain = (pick == 0) ? '0 : (pick == 1) ? '1 : STR_W'($urandom);
        pick = $urandom_range(0, 7);
        thr = (pick == 0) ? '0 : (pick == 1) ? '1 :
              (pick == 2) ? PIX_W'($urandom_range(0, 20)) : PIX_W'($urandom);
        // unused upper data bits must be ignored
        write_reg(CFG_STRENGTH, {5'($urandom), gain});
        write_reg(CFG_THRESHOLD, {4'($urandom), thr});
    endtask

    // One frame plus its flush tail, with stray dropped items mixed in; may stop early when may_abort is set.
    task automatic send_frame(input bit may_abort, input pix_style_t style, output bit cut);
        int   w, h, total, stop_at, k, level;
        t_in  stim;
        w = eff_w();
        h = eff_h();
        total = w * h + w + 1;
        stop_at = may_abort ? int'($urandom_range(0, total - 1)) : -1;
        level = 128;
        cut = 1'b0;
        for (k = 0; k < total; k++) begin
            if (k == stop_at) begin
                cut = 1'b1;
                return;
            end
            if (k < w * h) begin
                if ($urandom_range(0, 24) == 0) begin
                    stim.pixel = PIX_W'($urandom);
                    stim.flush = 1'b1;
                    send_item(stim, 1'b0, '0);
                end
                case (style)
                    STY_NOISE: stim.pixel = PIX_W'($urandom);
                    STY_RAMP: begin
                        level = level + int'($urandom_range(0, 16)) - 8;
                        if (level < 0) level = 0;
                        if (level > 255) level = 255;
                        stim.pixel = PIX_W'(level);
                    end
                    default: stim.pixel = $urandom_range(0, 1) ?
                                          PIX_W'(255 - $urandom_range(0, 24)) :
                                          PIX_W'($urandom_range(0, 24));
                endcase
                stim.flush = 1'b0;
            end else begin
                if ($urandom_range(0, 24) == 0) begin
                    stim.pixel = PIX_W'($urandom);
                    stim.flush = 1'b0;
                    send_item(stim, 1'b0, '0);
                end
                stim.pixel = PIX_W'($urandom);
                stim.flush = 1'b1;
            end
            send_item(stim, 1'b0, '0);
            real_items++;
        end
        frames_done++;
    endtask

    initial begin : stimulus
        int                i, pick, nfr, f;
        bit                last_item, cut;
        t_in               stim;
        logic [CFG_DW-1:0] wd, hd;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= '0;
        cfg_w    = RST_WIDTH;
        cfg_h    = RST_HEIGHT;
        cfg_gain = RST_STRENGTH;
        cfg_thr  = RST_THRESHOLD;
        for (i = 0; i < LINE_MAX; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 9; i++) win[i] = '0;
        rewind_frame();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        last_item = 1'b0;
        for (i = 0; i < DIR_N; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                if (last_item) drain();
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
                last_item = 1'b0;
            end else begin
                stim.pixel = DIRECTED[i].val[PIX_W-1:0];
                stim.flush = (DIRECTED[i].kind == ROW_FLUSH);
                send_item(stim, DIRECTED[i].typed, DIRECTED[i].want);
                last_item = 1'b1;
            end
        end

        cut = 1'b0;
        while (real_items < RAND_ITEMS) begin
            no_stall = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 15);
            wd = (pick == 0) ? CFG_DW'($urandom_range(0, 2)) :
                 (pick == 1) ? CFG_DW'($urandom_range(13, 40)) :
                 CFG_DW'($urandom_range(3, 12));
            pick = $urandom_range(0, 15);
            hd = (pick == 0) ? CFG_DW'($urandom_range(0, 2)) :
                 (pick == 1) ? CFG_DW'($urandom_range(9, 16)) :
                 CFG_DW'($urandom_range(3, 8));
            // after an abandoned frame the geometry must be rewritten to restart
            program_frame(cut || $urandom_range(0, 3) != 0, wd, hd);
            nfr = $urandom_range(1, 3);
            for (f = 0; f < nfr; f++)
                send_frame(f == nfr - 1 && $urandom_range(0, 7) == 0,
                           pix_style_t'($urandom_range(0, 2)), cut);
        end

        drain();

        $display("Sent %0d stream items over %0d frames and %0d register phases",
                 items_sent, frames_done, phases);
        $display("Checked %0d output pixels, lines 3 to 40 wide, frames 3 to 16 lines tall",
                 results_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
